// ===== hw/rtl/cvg_pkg.sv =====
// ----------------------------------------------------------------------------
// Cone vertex generator package
// Shared widths, register codes, reset values, CORDIC constants and the
// bundles that pass between the configuration, CORDIC and scaling units.
// ----------------------------------------------------------------------------
`default_nettype none

package cvg_pkg;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_CONE_RADIUS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_RADIAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_UP     = 2'd3;

    // Field widths.
    localparam int LEN_W     = 24;
    localparam int NORM_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int HFRAC_W   = 17;
    localparam int POS_UP_W  = 24;
    localparam int POS_RAD_W = 25;
    localparam int TRIG_W    = 17;

    // Register reset values.
    localparam logic [LEN_W-1:0]  RST_CONE_RADIUS   = 24'd65536;
    localparam logic [LEN_W-1:0]  RST_CONE_HEIGHT   = 24'd65536;
    localparam logic [NORM_W-1:0] RST_NORMAL_RADIAL = 16'd23170;
    localparam logic [NORM_W-1:0] RST_NORMAL_UP     = 16'd23170;

    // CORDIC datapath: Q1.30 vectors, angle in 2^-32 turn units.
    localparam int CORDIC_W   = 32;
    localparam int ATAN_W     = 30;
    localparam int ATAN_COUNT = 24;
    localparam logic signed [CORDIC_W-1:0] CORDIC_K = 32'sd652032874;

    localparam logic [ATAN_W-1:0] ATAN_TURNS [ATAN_COUNT] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // Live configuration values.
    typedef struct packed {
        logic [LEN_W-1:0]  cone_radius;
        logic [LEN_W-1:0]  cone_height;
        logic [NORM_W-1:0] normal_radial;
        logic [NORM_W-1:0] normal_up;
    } cvg_cfg_t;

    // One request leaving the CORDIC: Q1.15 cosine and sine plus height.
    typedef struct packed {
        logic                     valid;
        logic signed [TRIG_W-1:0] cos_val;
        logic signed [TRIG_W-1:0] sin_val;
        logic [HFRAC_W-1:0]       height;
    } cvg_trig_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cvg_regs.sv =====
// ----------------------------------------------------------------------------
// Cone vertex generator configuration registers
// Decodes register writes and holds radius, height and normal weights.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_regs
    import cvg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cvg_cfg_t                   cfg
);

    cvg_cfg_t cfg_reg;
    cvg_cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register decode; writes to an unused index leave everything alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CONE_RADIUS:   cfg_next.cone_radius   = cfg_data[LEN_W-1:0];
                REG_CONE_HEIGHT:   cfg_next.cone_height   = cfg_data[LEN_W-1:0];
                REG_NORMAL_RADIAL: cfg_next.normal_radial = cfg_data[NORM_W-1:0];
                REG_NORMAL_UP:     cfg_next.normal_up     = cfg_data[NORM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cone_radius   <= RST_CONE_RADIUS;
            cfg_reg.cone_height   <= RST_CONE_HEIGHT;
            cfg_reg.normal_radial <= RST_NORMAL_RADIAL;
            cfg_reg.normal_up     <= RST_NORMAL_UP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cvg_cordic.sv =====
// ----------------------------------------------------------------------------
// Cone vertex generator CORDIC
// Pipelined rotation-mode CORDIC, one iteration per stage, followed by a
// stage that rounds to Q1.15, clamps and unfolds the quadrant.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_cordic
    import cvg_pkg::*;
#(
    parameter int ITERATIONS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic [ANGLE_W-1:0] angle,
    input  wire logic [HFRAC_W-1:0] height,
    output cvg_trig_t               trig
);

    localparam int STAGES = (ITERATIONS > ATAN_COUNT) ? ATAN_COUNT : ITERATIONS;
    localparam int FRAC_BITS = ANGLE_W - 2;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    localparam logic signed [CORDIC_W-1:0] ROUND_HALF = 32'sd16384;
    localparam logic signed [CORDIC_W-1:0] TRIG_MAX   = 32'sd32768;
    localparam logic signed [CORDIC_W-1:0] TRIG_MIN   = -32'sd32768;

    // Iteration stage registers.
    logic signed [CORDIC_W-1:0] x_reg  [STAGES];
    logic signed [CORDIC_W-1:0] y_reg  [STAGES];
    logic signed [CORDIC_W-1:0] z_reg  [STAGES];
    logic signed [CORDIC_W-1:0] x_next [STAGES];
    logic signed [CORDIC_W-1:0] y_next [STAGES];
    logic signed [CORDIC_W-1:0] z_next [STAGES];
    logic [1:0]                 quad_reg  [STAGES];
    logic [1:0]                 quad_next [STAGES];
    logic [HFRAC_W-1:0]         hf_reg    [STAGES];
    logic [HFRAC_W-1:0]         hf_next   [STAGES];
    logic [STAGES-1:0]          valid_reg;
    logic [STAGES-1:0]          valid_next;

    // Fold stage registers.
    logic                       fold_valid_reg;
    logic signed [TRIG_W-1:0]   cos_reg;
    logic signed [TRIG_W-1:0]   sin_reg;
    logic signed [TRIG_W-1:0]   cos_next;
    logic signed [TRIG_W-1:0]   sin_next;
    logic [HFRAC_W-1:0]         fold_hf_reg;

    // One micro-rotation per stage; each stage reads only its predecessor.
    always_comb
    begin
        logic signed [CORDIC_W-1:0] xi;
        logic signed [CORDIC_W-1:0] yi;
        logic signed [CORDIC_W-1:0] zi;
        logic signed [CORDIC_W-1:0] atan_ext;
        for (int i = 0; i < STAGES; i++)
        begin
            if (i == 0)
            begin
                xi = CORDIC_K;
                yi = '0;
                zi = signed'({{(CORDIC_W-FRAC_BITS-16){1'b0}},
                              angle[FRAC_BITS-1:0], 16'b0});
                quad_next[i]  = angle[ANGLE_W-1:ANGLE_W-2];
                hf_next[i]    = height;
                valid_next[i] = in_valid;
            end
            else
            begin
                xi = x_reg[i-1];
                yi = y_reg[i-1];
                zi = z_reg[i-1];
                quad_next[i]  = quad_reg[i-1];
                hf_next[i]    = hf_reg[i-1];
                valid_next[i] = valid_reg[i-1];
            end
            atan_ext = signed'({{(CORDIC_W-ATAN_W){1'b0}}, ATAN_TURNS[i]});
            if (!zi[CORDIC_W-1])
            begin
                x_next[i] = xi - (yi >>> i);
                y_next[i] = yi + (xi >>> i);
                z_next[i] = zi - atan_ext;
            end
            else
            begin
                x_next[i] = xi + (yi >>> i);
                y_next[i] = yi - (xi >>> i);
                z_next[i] = zi + atan_ext;
            end
        end
    end

    // Round to Q1.15, clamp and rotate back into the original quadrant.
    always_comb
    begin
        logic signed [CORDIC_W-1:0] xr;
        logic signed [CORDIC_W-1:0] yr;
        logic signed [TRIG_W-1:0]   xs;
        logic signed [TRIG_W-1:0]   ys;
        xr = (x_reg[STAGES-1] + ROUND_HALF) >>> 15;
        yr = (y_reg[STAGES-1] + ROUND_HALF) >>> 15;
        if (xr > TRIG_MAX)
            xs = TRIG_MAX[TRIG_W-1:0];
        else if (xr < TRIG_MIN)
            xs = TRIG_MIN[TRIG_W-1:0];
        else
            xs = xr[TRIG_W-1:0];
        if (yr > TRIG_MAX)
            ys = TRIG_MAX[TRIG_W-1:0];
        else if (yr < TRIG_MIN)
            ys = TRIG_MIN[TRIG_W-1:0];
        else
            ys = yr[TRIG_W-1:0];
        case (quad_reg[STAGES-1])
            QUAD_FIRST:
            begin
                cos_next = xs;
                sin_next = ys;
            end
            QUAD_SECOND:
            begin
                cos_next = -ys;
                sin_next = xs;
            end
            QUAD_THIRD:
            begin
                cos_next = -xs;
                sin_next = -ys;
            end
            QUAD_FOURTH:
            begin
                cos_next = ys;
                sin_next = -xs;
            end
            default:
            begin
                cos_next = xs;
                sin_next = ys;
            end
        endcase
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            fold_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg      <= valid_next;
            fold_valid_reg <= valid_reg[STAGES-1];
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                x_reg[i]    <= x_next[i];
                y_reg[i]    <= y_next[i];
                z_reg[i]    <= z_next[i];
                quad_reg[i] <= quad_next[i];
                hf_reg[i]   <= hf_next[i];
            end
            cos_reg     <= cos_next;
            sin_reg     <= sin_next;
            fold_hf_reg <= hf_reg[STAGES-1];
        end
    end

    assign trig.valid   = fold_valid_reg;
    assign trig.cos_val = cos_reg;
    assign trig.sin_val = sin_reg;
    assign trig.height  = fold_hf_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cvg_scale.sv =====
// ----------------------------------------------------------------------------
// Cone vertex generator scaling pipeline
// Three stages: the first multiplies by radius, height and normal weight,
// the second multiplies the radial term by cosine and sine and rounds the
// short products, the third rounds the radial position and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cvg_scale
    import cvg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    adv,
    input  wire cvg_trig_t               trig,
    input  wire cvg_cfg_t                cfg,
    output logic                         out_valid,
    output logic signed [POS_UP_W-1:0]   pos_up,
    output logic signed [POS_RAD_W-1:0]  pos_radial_a,
    output logic signed [POS_RAD_W-1:0]  pos_radial_b,
    output logic signed [NORM_W-1:0]     norm_up,
    output logic signed [NORM_W-1:0]     norm_radial_a,
    output logic signed [NORM_W-1:0]     norm_radial_b
);

    localparam int OFS_W      = HFRAC_W + 1;
    localparam int PROD_W     = OFS_W + LEN_W + 1;
    localparam int NPROD_W    = NORM_W + 1 + TRIG_W;
    localparam int RPROD_W    = PROD_W + TRIG_W;

    localparam logic signed [OFS_W-1:0]   HALF_HEIGHT = OFS_W'(32768);
    localparam logic signed [OFS_W-1:0]   FULL_HEIGHT = OFS_W'(65536);
    localparam logic signed [PROD_W-1:0]  UP_ROUND    = PROD_W'(32768);
    localparam logic signed [PROD_W-1:0]  UP_MAX      = PROD_W'(2**(POS_UP_W-1) - 1);
    localparam logic signed [PROD_W-1:0]  UP_MIN      = PROD_W'(-(2**(POS_UP_W-1)));
    localparam logic signed [NPROD_W-1:0] N_ROUND     = NPROD_W'(16384);
    localparam logic signed [NPROD_W-1:0] N_MAX       = NPROD_W'(2**(NORM_W-1) - 1);
    localparam logic signed [NPROD_W-1:0] N_MIN       = NPROD_W'(-(2**(NORM_W-1)));
    localparam logic signed [RPROD_W-1:0] R_ROUND     = RPROD_W'(64'sd1 <<< 30);
    localparam logic signed [RPROD_W-1:0] R_MAX       = RPROD_W'(2**(POS_RAD_W-1) - 1);
    localparam logic signed [RPROD_W-1:0] R_MIN       = RPROD_W'(-(2**(POS_RAD_W-1)));
    localparam logic [NORM_W-1:0]         NU_MAX      = NORM_W'(2**(NORM_W-1) - 1);

    // Stage A registers.
    logic                       a_valid_reg;
    logic signed [PROD_W-1:0]   a_up_reg;
    logic signed [PROD_W-1:0]   a_up_next;
    logic signed [PROD_W-1:0]   a_rp_reg;
    logic signed [PROD_W-1:0]   a_rp_next;
    logic signed [NPROD_W-1:0]  a_na_reg;
    logic signed [NPROD_W-1:0]  a_na_next;
    logic signed [NPROD_W-1:0]  a_nb_reg;
    logic signed [NPROD_W-1:0]  a_nb_next;
    logic signed [TRIG_W-1:0]   a_cos_reg;
    logic signed [TRIG_W-1:0]   a_sin_reg;

    // Stage B registers.
    logic                       b_valid_reg;
    logic signed [RPROD_W-1:0]  b_ra_reg;
    logic signed [RPROD_W-1:0]  b_ra_next;
    logic signed [RPROD_W-1:0]  b_rb_reg;
    logic signed [RPROD_W-1:0]  b_rb_next;
    logic signed [POS_UP_W-1:0] b_up_reg;
    logic signed [POS_UP_W-1:0] b_up_next;
    logic signed [NORM_W-1:0]   b_na_reg;
    logic signed [NORM_W-1:0]   b_na_next;
    logic signed [NORM_W-1:0]   b_nb_reg;
    logic signed [NORM_W-1:0]   b_nb_next;

    // Output registers.
    logic                        out_valid_reg;
    logic signed [POS_UP_W-1:0]  pos_up_reg;
    logic signed [POS_RAD_W-1:0] pos_ra_reg;
    logic signed [POS_RAD_W-1:0] pos_ra_next;
    logic signed [POS_RAD_W-1:0] pos_rb_reg;
    logic signed [POS_RAD_W-1:0] pos_rb_next;
    logic signed [NORM_W-1:0]    norm_up_reg;
    logic signed [NORM_W-1:0]    norm_up_next;
    logic signed [NORM_W-1:0]    norm_ra_reg;
    logic signed [NORM_W-1:0]    norm_rb_reg;

    // Stage A: height offsets times the lengths, normal weight times trig.
    always_comb
    begin
        logic signed [OFS_W-1:0]  hf;
        logic signed [OFS_W-1:0]  up_ofs;
        logic signed [OFS_W-1:0]  rad_ofs;
        logic signed [LEN_W:0]    height_s;
        logic signed [LEN_W:0]    radius_s;
        logic signed [NORM_W:0]   nrad_s;
        hf       = signed'({1'b0, trig.height});
        up_ofs   = hf - HALF_HEIGHT;
        rad_ofs  = FULL_HEIGHT - hf;
        height_s = signed'({1'b0, cfg.cone_height});
        radius_s = signed'({1'b0, cfg.cone_radius});
        nrad_s   = signed'({1'b0, cfg.normal_radial});
        a_up_next = PROD_W'(up_ofs) * PROD_W'(height_s);
        a_rp_next = PROD_W'(rad_ofs) * PROD_W'(radius_s);
        a_na_next = NPROD_W'(nrad_s) * NPROD_W'(trig.cos_val);
        a_nb_next = NPROD_W'(nrad_s) * NPROD_W'(trig.sin_val);
    end

    // Stage B: radial products, axial and normal rounding with saturation.
    always_comb
    begin
        logic signed [PROD_W-1:0]  up_r;
        logic signed [NPROD_W-1:0] na_r;
        logic signed [NPROD_W-1:0] nb_r;
        b_ra_next = RPROD_W'(a_rp_reg) * RPROD_W'(a_cos_reg);
        b_rb_next = RPROD_W'(a_rp_reg) * RPROD_W'(a_sin_reg);
        up_r = (a_up_reg + UP_ROUND) >>> 16;
        na_r = (a_na_reg + N_ROUND) >>> 15;
        nb_r = (a_nb_reg + N_ROUND) >>> 15;
        if (up_r > UP_MAX)
            b_up_next = UP_MAX[POS_UP_W-1:0];
        else if (up_r < UP_MIN)
            b_up_next = UP_MIN[POS_UP_W-1:0];
        else
            b_up_next = up_r[POS_UP_W-1:0];
        if (na_r > N_MAX)
            b_na_next = N_MAX[NORM_W-1:0];
        else if (na_r < N_MIN)
            b_na_next = N_MIN[NORM_W-1:0];
        else
            b_na_next = na_r[NORM_W-1:0];
        if (nb_r > N_MAX)
            b_nb_next = N_MAX[NORM_W-1:0];
        else if (nb_r < N_MIN)
            b_nb_next = N_MIN[NORM_W-1:0];
        else
            b_nb_next = nb_r[NORM_W-1:0];
    end

    // Stage C: round the radial positions; clamp the axial normal weight.
    always_comb
    begin
        logic signed [RPROD_W-1:0] ra_r;
        logic signed [RPROD_W-1:0] rb_r;
        ra_r = (b_ra_reg + R_ROUND) >>> 31;
        rb_r = (b_rb_reg + R_ROUND) >>> 31;
        if (ra_r > R_MAX)
            pos_ra_next = R_MAX[POS_RAD_W-1:0];
        else if (ra_r < R_MIN)
            pos_ra_next = R_MIN[POS_RAD_W-1:0];
        else
            pos_ra_next = ra_r[POS_RAD_W-1:0];
        if (rb_r > R_MAX)
            pos_rb_next = R_MAX[POS_RAD_W-1:0];
        else if (rb_r < R_MIN)
            pos_rb_next = R_MIN[POS_RAD_W-1:0];
        else
            pos_rb_next = rb_r[POS_RAD_W-1:0];
        if (cfg.normal_up > NU_MAX)
            norm_up_next = NU_MAX;
        else
            norm_up_next = cfg.normal_up;
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= trig.valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_up_reg    <= a_up_next;
            a_rp_reg    <= a_rp_next;
            a_na_reg    <= a_na_next;
            a_nb_reg    <= a_nb_next;
            a_cos_reg   <= trig.cos_val;
            a_sin_reg   <= trig.sin_val;
            b_ra_reg    <= b_ra_next;
            b_rb_reg    <= b_rb_next;
            b_up_reg    <= b_up_next;
            b_na_reg    <= b_na_next;
            b_nb_reg    <= b_nb_next;
            pos_up_reg  <= b_up_reg;
            pos_ra_reg  <= pos_ra_next;
            pos_rb_reg  <= pos_rb_next;
            norm_up_reg <= norm_up_next;
            norm_ra_reg <= b_na_reg;
            norm_rb_reg <= b_nb_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pos_up        = pos_up_reg;
    assign pos_radial_a  = pos_ra_reg;
    assign pos_radial_b  = pos_rb_reg;
    assign norm_up       = norm_up_reg;
    assign norm_radial_a = norm_ra_reg;
    assign norm_radial_b = norm_rb_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/cone_vertex_generator_unit.sv =====
// Pipeline from request acceptance to result valid: one stage per CORDIC
// iteration, one fold stage, three scaling stages.
// Throughput: one request per cycle; the whole pipeline advances together
// and holds while a finished result waits under out_stall.
// Reset clears all valid bits and loads the register reset values;
// no clearing pass is needed, requests are taken right after reset.
// ----------------------------------------------------------------------------
// Cone vertex generator unit
// Turns an angle and height fraction into a cone-surface position and normal.
// ----------------------------------------------------------------------------
`default_nettype none

module cone_vertex_generator_unit
    import cvg_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [ANGLE_W-1:0]     angle_fraction,
    input  wire logic [HFRAC_W-1:0]     height_fraction,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [POS_UP_W-1:0]  pos_up,
    output logic signed [POS_RAD_W-1:0] pos_radial_a,
    output logic signed [POS_RAD_W-1:0] pos_radial_b,
    output logic signed [NORM_W-1:0]    norm_up,
    output logic signed [NORM_W-1:0]    norm_radial_a,
    output logic signed [NORM_W-1:0]    norm_radial_b,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ITERS   = (ANGLE_BITS > ATAN_COUNT) ? ATAN_COUNT : ANGLE_BITS;
    localparam int LATENCY = ITERS + 4;
    localparam int CNT_W   = $clog2(LATENCY + 2);

    logic      adv;
    cvg_cfg_t  cfg;
    cvg_trig_t trig;

    // The pipeline moves unless a finished result is held back.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    cvg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cvg_cordic #(
        .ITERATIONS (ANGLE_BITS)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .angle    (angle_fraction),
        .height   (height_fraction),
        .trig     (trig)
    );

    cvg_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .trig          (trig),
        .cfg           (cfg),
        .out_valid     (out_valid),
        .pos_up        (pos_up),
        .pos_radial_a  (pos_radial_a),
        .pos_radial_b  (pos_radial_b),
        .norm_up       (norm_up),
        .norm_radial_a (norm_radial_a),
        .norm_radial_b (norm_radial_b)
    );

    // Requests in flight, for the checks below.
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg
                        + CNT_W'(in_valid && !in_stall)
                        - CNT_W'(out_valid && !out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // A result is only shown for a request that was taken.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != '0))
        else $error("result valid with no request in flight");

    // The pipeline never holds more requests than it has stages.
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(LATENCY))
        else $error("more requests in flight than pipeline stages");

    // The axial normal is clamped to a non-negative Q1.15 value.
    a_norm_up_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !norm_up[NORM_W-1])
        else $error("axial normal came out negative");

endmodule

`default_nettype wire
